@@ rtl/cqs_pkg.sv @@
// -----------------------------------------------------------------------------
// cqs_pkg
// shared types and constants of the circular queue with search
// -----------------------------------------------------------------------------
package cqs_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int QSIZE_W          = 7;
   localparam int QSIZE_RESET      = 64;
   localparam int VALUE_W          = 32;
   localparam int POS_W            = 6;
   localparam int STATUS_W         = 2;
   localparam int CMD_W            = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_DISPLAY = 2'd2,
      CMD_SEARCH  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } resp_status_type;

   // which result the datapath builds when told to emit
   typedef enum logic [2:0] {
      RES_ENQ_OK,
      RES_FULL,
      RES_EMPTY,
      RES_DEQ,
      RES_DISP,
      RES_HIT,
      RES_MISS
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_EMPTY,
      ST_DEQ,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic         capture;    // latch request, read head slot, start walk
      logic         enq_write;  // write value at new tail
      logic         deq_pop;    // drop head entry
      logic         walk_step;  // advance walk pointer and read next slot
      logic         emit;       // load result register
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic    out_free;   // result register can take a result this cycle
      logic    empty;
      logic    full;
      logic    walk_last;  // walk offset is the newest entry
      logic    match;      // slot read equals search value
      cmd_type cmd;        // latched command
   } dp_sts_type;

endpackage

@@ rtl/cqs_ctrl.sv @@
// -----------------------------------------------------------------------------
// cqs_ctrl
// sequencer for enqueue, dequeue, display and search
// -----------------------------------------------------------------------------
module cqs_ctrl
   import cqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  cmd_type    req_command,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.kind      = RES_ENQ_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               priority if (req_command == CMD_ENQUEUE) begin
                  state_in = ST_ENQ;
               end else if (sts.empty) begin
                  state_in = ST_EMPTY;
               end else if (req_command == CMD_DEQUEUE) begin
                  state_in = ST_DEQ;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_ENQ: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.full) begin
                  cmd.kind = RES_FULL;
               end else begin
                  cmd.kind      = RES_ENQ_OK;
                  cmd.enq_write = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = RES_EMPTY;
               state_in = ST_IDLE;
            end
         end
         ST_DEQ: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = RES_DEQ;
               cmd.deq_pop = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WALK: begin
            priority if (sts.cmd == CMD_DISPLAY) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = RES_DISP;
                  if (sts.walk_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.walk_step = 1'b1;
                  end
               end
            end else if (sts.match) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = RES_HIT;
                  state_in = ST_IDLE;
               end
            end else if (sts.walk_last) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = RES_MISS;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/cqs_datapath.sv @@
// -----------------------------------------------------------------------------
// cqs_datapath
// slot memory, head/tail pointers, walk pointer and result register
// -----------------------------------------------------------------------------
module cqs_datapath
   import cqs_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   // request payload
   input  cmd_type                    req_command,
   input  logic signed [VALUE_W-1:0]  req_value,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [QSIZE_W-1:0]  csr_queue_size,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_data,
   output logic        [POS_W-1:0]    rsp_position,
   output logic                       rsp_last,
   // control
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts
);

   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int SZ_W      = (CNT_W > QSIZE_W) ? CNT_W : QSIZE_W;
   localparam int EFF_RESET = (QSIZE_RESET > CAPACITY) ? CAPACITY :
                              ((QSIZE_RESET < 1) ? 1 : QSIZE_RESET);

   logic [VALUE_W-1:0] slot_mem [CAPACITY];

   logic        [CNT_W-1:0]    eff_size_ff, eff_size_in;
   logic        [CNT_W-1:0]    count_ff,    count_in;
   logic        [IDX_W-1:0]    head_ff,     head_in;
   logic        [IDX_W-1:0]    tail_ff,     tail_in;
   logic        [IDX_W-1:0]    walk_idx_ff, walk_idx_in;
   logic        [IDX_W-1:0]    walk_k_ff,   walk_k_in;
   cmd_type                    cmd_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic signed [VALUE_W-1:0]  rd_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic signed [VALUE_W-1:0]  rsp_data_ff;
   logic        [POS_W-1:0]    rsp_position_ff;
   logic                       rsp_last_ff;

   logic        [IDX_W-1:0]    tail_next;
   logic        [IDX_W-1:0]    head_next;
   logic        [IDX_W-1:0]    walk_next;
   logic        [IDX_W-1:0]    wr_addr;
   logic        [IDX_W-1:0]    rd_addr;
   logic                       rd_en;
   logic        [SZ_W-1:0]     qsize_ext;
   resp_status_type            res_status;
   logic signed [VALUE_W-1:0]  res_data;
   logic        [POS_W-1:0]    res_position;
   logic                       res_last;

   // ring increment, wrapping at the effective size
   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + 1'b1;
      return (nxt == size) ? '0 : nxt[IDX_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign qsize_ext = SZ_W'(csr_queue_size);

   assign tail_next = ring_inc(tail_ff, eff_size_ff);
   assign head_next = ring_inc(head_ff, eff_size_ff);
   assign walk_next = ring_inc(walk_idx_ff, eff_size_ff);
   assign wr_addr   = (count_ff == '0) ? '0 : tail_next;
   assign rd_en     = cmd.capture | cmd.walk_step;
   assign rd_addr   = cmd.walk_step ? walk_next : head_ff;

   // status to the controller
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == eff_size_ff);
   assign sts.walk_last = ((CNT_W'(walk_k_ff) + 1'b1) == count_ff);
   assign sts.match     = (rd_data_ff == value_ff);
   assign sts.cmd       = cmd_ff;

   // slot memory
   always_ff @(posedge clock) begin
      if (cmd.enq_write) begin
         slot_mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // pointers and size
   always_comb begin
      eff_size_in = eff_size_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      walk_idx_in = walk_idx_ff;
      walk_k_in   = walk_k_ff;
      if (csr_valid) begin
         priority if (qsize_ext == '0) begin
            eff_size_in = CNT_W'(1);
         end else if (qsize_ext > SZ_W'(CAPACITY)) begin
            eff_size_in = CNT_W'(CAPACITY);
         end else begin
            eff_size_in = CNT_W'(qsize_ext);
         end
         count_in = '0;
         head_in  = '0;
         tail_in  = '0;
      end else begin
         if (cmd.enq_write) begin
            tail_in  = wr_addr;
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               head_in = '0;
            end
         end
         if (cmd.deq_pop) begin
            if (count_ff == CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = head_next;
            end
            count_in = count_ff - 1'b1;
         end
      end
      if (cmd.capture) begin
         walk_idx_in = head_ff;
         walk_k_in   = '0;
      end else if (cmd.walk_step) begin
         walk_idx_in = walk_next;
         walk_k_in   = walk_k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_size_ff <= CNT_W'(EFF_RESET);
         count_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         eff_size_ff <= eff_size_in;
         count_ff    <= count_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      walk_k_ff   <= walk_k_in;
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
   end

   // result formatting
   always_comb begin
      res_status   = STS_OK;
      res_data     = '0;
      res_position = '0;
      res_last     = 1'b1;
      unique case (cmd.kind)
         RES_ENQ_OK: res_status = STS_OK;
         RES_FULL:   res_status = STS_FULL;
         RES_EMPTY:  res_status = STS_EMPTY;
         RES_DEQ:    res_data   = rd_data_ff;
         RES_DISP: begin
            res_data     = rd_data_ff;
            res_position = POS_W'(walk_k_ff);
            res_last     = sts.walk_last;
         end
         RES_HIT: begin
            res_data     = value_ff;
            res_position = POS_W'(walk_k_ff);
         end
         RES_MISS:   res_status = STS_NOT_FOUND;
         default:    res_status = STS_OK;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff   <= res_status;
         rsp_data_ff     <= res_data;
         rsp_position_ff <= res_position;
         rsp_last_ff     <= res_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ rtl/circular_queue_with_search_top.sv @@
// -----------------------------------------------------------------------------
// circular_queue_with_search_top
// ring buffer of signed 32-bit values with dequeue, display and search
// -----------------------------------------------------------------------------
// usage
//  - req_ channel: one transfer per command (enqueue, dequeue, display, search)
//    with req_value as the value to store or to look for
//  - rsp_ channel: results; display gives one transfer per stored entry,
//    every other command gives exactly one; rsp_last marks the final one
//  - csr_ channel: writes queue_size (saturated to 1..CAPACITY) and empties
//    the queue; only write while no command is outstanding
//  - a request transfer is captured first; enqueue, dequeue and any command
//    on an empty queue then load their result once the result register is
//    free; display loads one entry per cycle while the result register is
//    free; search walks from the head and stops at the first hit
//  - the walk rate is set by the single read port of the slot memory,
//    which delivers one registered slot per cycle
//  - one command is in progress at a time; the next request is taken as soon
//    as the sequencer is back in idle, even while a result still waits
//  - when the receiver stalls the result register holds and the sequencer
//    waits before loading the next result
//  - reset empties the queue and sets queue_size to 64 (capped at CAPACITY);
//    slot contents are not cleared and are only reported once written
// -----------------------------------------------------------------------------
module circular_queue_with_search_top
   import cqs_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic        [CMD_W-1:0]    req_command,
   input  logic signed [VALUE_W-1:0]  req_value,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_data,
   output logic        [POS_W-1:0]    rsp_position,
   output logic                       rsp_last,
   // configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [QSIZE_W-1:0]  csr_queue_size
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;
   cmd_type    req_cmd;

   assign req_cmd = cmd_type'(req_command);

   // sequencer: decides per state which datapath action runs
   cqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_cmd),
      .req_ready   (req_ready),
      .sts         (dp_sts),
      .cmd         (dp_cmd)
   );

   // storage, pointers and the result register
   cqs_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_cmd),
      .req_value      (req_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_queue_size (csr_queue_size),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .cmd            (dp_cmd),
      .sts            (dp_sts)
   );

`ifndef NO_ASSERTIONS
   // one command at a time: no request transfer right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in progress");

   // a result is only loaded when the output register can take it
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> dp_sts.out_free)
      else $error("result loaded over a waiting result");

   // never write into a full ring
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.enq_write |-> !dp_sts.full)
      else $error("enqueue into a full queue");

   // never pop an empty ring
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.deq_pop |-> !dp_sts.empty)
      else $error("dequeue from an empty queue");
`endif

endmodule

@@ bench/tb_top.sv @@
// -----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circular queue with search
// -----------------------------------------------------------------------------
// Commands go in through a backlog that a clocked driver drains onto the req_
// channel. A clocked monitor takes results off the rsp_ channel. A shadow ring
// is updated on every accepted command. It predicts each result, and every
// result must match the oldest prediction in each field. A directed opening
// covers the empty, full, hit, miss and first-match cases. Random phases
// follow with different queue sizes (out-of-range ones included), fill and
// drain biased command mixes, and sender and receiver idling. One phase holds
// the receiver off for a long stretch so that the block backs up.
// -----------------------------------------------------------------------------
module tb_top;
   import cqs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_CAPACITY = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int LONG_HOLD     = 250;  // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES = 6;    // quiet cycles after the last result
   localparam int POOL_DEPTH    = 8;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      cmd_type                    command;
      logic signed [VALUE_W-1:0]  value;
   } queue_cmd_type;

   typedef struct {
      resp_status_type            status;
      logic signed [VALUE_W-1:0]  data;
      logic        [POS_W-1:0]    position;
      logic                       last;
   } ring_result_type;

   // dut connections, the driven ones known from time zero
   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic        [CMD_W-1:0]    req_command    = '0;
   logic signed [VALUE_W-1:0]  req_value      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [VALUE_W-1:0]  rsp_data;
   logic        [POS_W-1:0]    rsp_position;
   logic                       rsp_last;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic        [QSIZE_W-1:0]  csr_queue_size = '0;

   // commands waiting to be offered, and results the shadow ring has produced
   queue_cmd_type   cmd_backlog[$];
   ring_result_type ring_results_due[$];

   // shadow ring, state as after reset
   logic signed [VALUE_W-1:0] ring_slot[RING_CAPACITY];
   int unsigned               ring_head     = 0;
   int unsigned               ring_tail     = 0;
   bit                        ring_is_empty = 1'b1;
   int unsigned               ring_size     = QSIZE_RESET;

   // idling control, written by the sequence at the falling edge only
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned long_hold_req  = 0;

   // bookkeeping
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;
   int unsigned cmds_taken     = 0;
   int unsigned results_seen   = 0;
   int unsigned size_writes    = 0;
   int unsigned deepest_fill   = 0;
   int unsigned status_tally[4];

   logic signed [VALUE_W-1:0] value_pool[POOL_DEPTH];

   circular_queue_with_search_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_queue_size (csr_queue_size)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // shadow ring
   // ---------------------------------------------------------------------------

   function automatic int unsigned ring_count();
      if (ring_is_empty) return 0;
      return ((ring_tail + ring_size - ring_head) % ring_size) + 1;
   endfunction

   function automatic void post_result(resp_status_type status,
                                       logic signed [VALUE_W-1:0] data,
                                       int unsigned offset, bit last);
      ring_result_type r;
      r.status   = status;
      r.data     = data;
      r.position = POS_W'(offset);   // offsets wider than the port wrap
      r.last     = last;
      ring_results_due.push_back(r);
   endfunction

   // a size write saturates to 1..capacity and always empties the ring
   function automatic void ring_resize(logic [QSIZE_W-1:0] qsize);
      if (qsize == 0)
         ring_size = 1;
      else if (qsize > RING_CAPACITY)
         ring_size = RING_CAPACITY;
      else
         ring_size = qsize;
      ring_head     = 0;
      ring_tail     = 0;
      ring_is_empty = 1'b1;
   endfunction

   // apply one accepted command and queue up the results it must produce
   function automatic void ring_execute(cmd_type cmd, logic signed [VALUE_W-1:0] val);
      int unsigned count;
      int unsigned idx;
      bit          found;
      count = ring_count();
      found = 1'b0;
      if (cmd == CMD_ENQUEUE) begin
         if (count >= ring_size) begin
            post_result(STS_FULL, '0, 0, 1'b1);
         end else begin
            if (ring_is_empty) begin
               ring_head     = 0;
               ring_tail     = 0;
               ring_is_empty = 1'b0;
            end else begin
               ring_tail = (ring_tail + 1) % ring_size;
            end
            ring_slot[ring_tail] = val;
            post_result(STS_OK, '0, 0, 1'b1);
            if (count + 1 > deepest_fill) deepest_fill = count + 1;
         end
      end else if (count == 0) begin
         // dequeue, display and search on an empty ring all give one empty status
         post_result(STS_EMPTY, '0, 0, 1'b1);
      end else if (cmd == CMD_DEQUEUE) begin
         post_result(STS_OK, ring_slot[ring_head], 0, 1'b1);
         if (count == 1) begin
            ring_head     = 0;
            ring_tail     = 0;
            ring_is_empty = 1'b1;
         end else begin
            ring_head = (ring_head + 1) % ring_size;
         end
      end else if (cmd == CMD_DISPLAY) begin
         for (int unsigned k = 0; k < count; k++) begin
            idx = (ring_head + k) % ring_size;
            post_result(STS_OK, ring_slot[idx], k, k + 1 == count);
         end
      end else begin
         // search stops at the first match counted from the head
         for (int unsigned k = 0; k < count && !found; k++) begin
            idx = (ring_head + k) % ring_size;
            if (ring_slot[idx] == val) begin
               post_result(STS_OK, val, k, 1'b1);
               found = 1'b1;
            end
         end
         if (!found) post_result(STS_NOT_FOUND, '0, 0, 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: offers the backlog, updates the shadow ring on transfers
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      queue_cmd_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // size writes only happen with nothing in flight
         if (csr_valid && csr_ready) ring_resize(csr_queue_size);
         if (req_valid && req_ready) begin
            ring_execute(cmd_type'(req_command), req_value);
            cmds_taken++;
         end
         // payload may only move once the current one has been transferred
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = cmd_backlog.pop_front();
               req_command <= item.command;
               req_value   <= item.value;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor: checks each transfer, drives the receiver's stalls
   // ---------------------------------------------------------------------------

   task automatic note_mismatch(string field, longint want, longint got);
      mismatches++;
      $display("%0t ns  rsp %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : watch_results
      ring_result_type want;
      int unsigned     hold_left;
      int unsigned     hold_seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            status_tally[rsp_status]++;
            if (ring_results_due.size() == 0) begin
               mismatches++;
               $display("%0t ns  rsp unexpected: status %0d data %0d position %0d last %0d",
                        $time, rsp_status, rsp_data, rsp_position, rsp_last);
            end else begin
               want = ring_results_due.pop_front();
               if (rsp_status !== want.status)
                  note_mismatch("status", want.status, rsp_status);
               if (rsp_data !== want.data)
                  note_mismatch("data", want.data, rsp_data);
               if (rsp_position !== want.position)
                  note_mismatch("position", want.position, rsp_position);
               if (rsp_last !== want.last)
                  note_mismatch("last", want.last, rsp_last);
            end
         end
         // a long hold-off requested by the sequence is counted down here
         if (long_hold_req != hold_seen) begin
            hold_seen = long_hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, ring_results_due.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   function automatic void push_cmd(cmd_type cmd, logic signed [VALUE_W-1:0] val);
      queue_cmd_type item;
      item.command = cmd;
      item.value   = val;
      cmd_backlog.push_back(item);
   endfunction

   // a small pool of values gives frequent search hits and duplicate entries
   function automatic void refresh_value_pool();
      for (int i = 0; i < POOL_DEPTH; i++) value_pool[i] = $urandom();
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return value_pool[$urandom_range(POOL_DEPTH - 1)];
      if (r < 52) begin
         case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom();
   endfunction

   // filling mixes lean on enqueue, draining mixes on dequeue and search
   function automatic cmd_type pick_command(bit filling);
      int unsigned r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 60) return CMD_ENQUEUE;
         if (r < 72) return CMD_DEQUEUE;
         if (r < 80) return CMD_DISPLAY;
         return CMD_SEARCH;
      end
      if (r < 15) return CMD_ENQUEUE;
      if (r < 60) return CMD_DEQUEUE;
      if (r < 70) return CMD_DISPLAY;
      return CMD_SEARCH;
   endfunction

   function automatic void push_mix(int n, bit filling);
      for (int i = 0; i < n; i++) push_cmd(pick_command(filling), pick_value());
   endfunction

   // sender holds back until every command has been answered
   task automatic wait_quiet();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || ring_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_queue_size(logic [QSIZE_W-1:0] qsize);
      @(posedge clock);
      csr_queue_size <= qsize;
      csr_valid      <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      size_writes++;
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   // one random phase: new size, a filling half, a pause, then a draining half
   task automatic run_phase(logic [QSIZE_W-1:0] qsize, int unsigned send_pct,
                            int unsigned stall_pct, int n);
      wait_quiet();
      write_queue_size(qsize);
      set_idling(send_pct, stall_pct);
      refresh_value_pool();
      push_mix(n / 2, 1'b1);
      wait_quiet();
      push_mix(n - n / 2, 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases at the reset size
      push_cmd(CMD_DEQUEUE, '0);
      push_cmd(CMD_DISPLAY, '0);
      push_cmd(CMD_SEARCH, '0);
      // extremes and alternating bit patterns, with a duplicate
      push_cmd(CMD_ENQUEUE, VAL_MIN);
      push_cmd(CMD_ENQUEUE, VAL_MAX);
      push_cmd(CMD_ENQUEUE, '0);
      push_cmd(CMD_ENQUEUE, -1);
      push_cmd(CMD_ENQUEUE, 32'sh5555_5555);
      push_cmd(CMD_ENQUEUE, 32'shaaaa_aaaa);
      push_cmd(CMD_ENQUEUE, -1);
      push_cmd(CMD_SEARCH, VAL_MAX);       // hit one place after the head
      push_cmd(CMD_SEARCH, -1);            // first of two matches
      push_cmd(CMD_SEARCH, 12345);         // miss
      push_cmd(CMD_DISPLAY, '0);
      push_cmd(CMD_DEQUEUE, '0);
      wait_quiet();

      // directed: single-slot ring, full and back to empty
      write_queue_size(1);
      @(negedge clock);
      push_cmd(CMD_ENQUEUE, 7);
      push_cmd(CMD_ENQUEUE, 8);            // full, value dropped
      push_cmd(CMD_DISPLAY, '0);
      push_cmd(CMD_SEARCH, 7);
      push_cmd(CMD_SEARCH, 8);
      push_cmd(CMD_DEQUEUE, '0);
      push_cmd(CMD_DEQUEUE, '0);
      wait_quiet();

      // oversized write acts as full capacity: fill every slot, then wrap
      write_queue_size(127);
      set_idling(0, 0);
      refresh_value_pool();
      repeat (RING_CAPACITY + 2) push_cmd(CMD_ENQUEUE, pick_value());
      push_cmd(CMD_DISPLAY, '0);
      push_cmd(CMD_SEARCH, value_pool[0]);
      push_cmd(CMD_SEARCH, $urandom());
      push_mix(24, 1'b0);

      run_phase(3,   52, 0,  60);
      run_phase(0,   0,  52, 40);           // zero acts as one slot
      run_phase(17,  25, 25, 60);
      run_phase(7'($urandom_range(1, RING_CAPACITY)), 0, 0, 56);
      run_phase(2,   52, 0,  48);

      // back-pressure: receiver holds off while the sender keeps offering
      wait_quiet();
      write_queue_size(QSIZE_W'(RING_CAPACITY));
      set_idling(0, 0);
      refresh_value_pool();
      long_hold_req++;
      push_mix(40, 1'b1);

      run_phase(7'($urandom_range(1, RING_CAPACITY)), 0, 52, 60);
      run_phase(5,   25, 25, 30);

      wait_quiet();
      $display("run covered %0d commands and %0d results over %0d size writes, ring filled to %0d",
               cmds_taken, results_seen, size_writes, deepest_fill);
      $display("status mix: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
               status_tally[STS_OK], status_tally[STS_FULL], status_tally[STS_EMPTY],
               status_tally[STS_NOT_FOUND], mismatches);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
